// ----- rtl/grid_automaton_step_assert.svh -----
// assertion macros for the grid automaton step block
// expects clk_i in the scope of every use, and rst_ni for GAS_ASSERT
`ifndef GRID_AUTOMATON_STEP_ASSERT_SVH
`define GRID_AUTOMATON_STEP_ASSERT_SVH
`ifndef SYNTHESIS
`define GAS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
`define GAS_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);
`else
`define GAS_ASSERT(lbl, prop, msg)
`define GAS_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

// ----- rtl/gas_pkg.sv -----
// shared types and constants of the grid automaton step block
// no dependencies
`default_nettype none

package gas_pkg;

  localparam int unsigned DefMaxWidth  = 256;
  localparam int unsigned DefMaxHeight = 4096;

  localparam int unsigned CellW       = 8;
  localparam int unsigned CfgIdxW     = 3;
  localparam int unsigned CfgDataW    = 13;
  localparam int unsigned GridWidthW  = 9;
  localparam int unsigned GridHeightW = 13;
  localparam int unsigned LimitW      = 4;

  localparam logic [GridWidthW-1:0]  RstGridWidth  = 9'd30;
  localparam logic [GridHeightW-1:0] RstGridHeight = 13'd15;
  localparam logic [CellW-1:0]       RstAliveValue = 8'd88;
  localparam logic [CellW-1:0]       RstDeadValue  = 8'd46;
  localparam logic [LimitW-1:0]      RstBirthLimit = 4'd4;
  localparam logic [LimitW-1:0]      RstDeathLimit = 4'd3;

  typedef enum logic [CfgIdxW-1:0] {
    REG_GRID_WIDTH  = 3'd0,
    REG_GRID_HEIGHT = 3'd1,
    REG_ALIVE_VALUE = 3'd2,
    REG_DEAD_VALUE  = 3'd3,
    REG_BIRTH_LIMIT = 3'd4,
    REG_DEATH_LIMIT = 3'd5
  } gas_reg_e;

  typedef logic [CellW-1:0] gas_cell_t;

  // [column][row], column 0 left, row 0 top
  typedef gas_cell_t [2:0][2:0] gas_window_t;
  typedef logic [2:0][2:0] gas_mask_t;

  typedef struct packed {
    gas_cell_t         alive_value;
    gas_cell_t         dead_value;
    logic [LimitW-1:0] birth_limit;
    logic [LimitW-1:0] death_limit;
  } gas_rule_cfg_t;

  typedef struct packed {
    logic rd_en;
    logic wr_en;
    logic shift;
  } gas_buf_ctrl_t;

endpackage

`default_nettype wire

// ----- rtl/gas_window.sv -----
// two row line buffers and the 3x3 neighbourhood window registers
// depends on gas_pkg
`default_nettype none

module gas_window #(
  parameter int unsigned MaxWidth = gas_pkg::DefMaxWidth
) (
  input  logic                          clk_i,
  input  gas_pkg::gas_buf_ctrl_t        ctrl_i,
  input  logic [$clog2(MaxWidth)-1:0]   rd_addr_i,
  input  logic [$clog2(MaxWidth)-1:0]   wr_addr_i,
  input  gas_pkg::gas_cell_t            cell_i,
  output gas_pkg::gas_window_t          window_o
);
  import gas_pkg::*;

  gas_cell_t       upper_mem [MaxWidth];
  gas_cell_t       lower_mem [MaxWidth];
  gas_cell_t       upper_raw_q;
  gas_cell_t       lower_raw_q;
  gas_cell_t       upper_byp_q;
  gas_cell_t       lower_byp_q;
  logic            byp_q;
  gas_cell_t       upper_rd;
  gas_cell_t       lower_rd;
  gas_cell_t [2:0] incoming;
  gas_cell_t [2:0] left_q;
  gas_cell_t [2:0] centre_q;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.wr_en) begin
      upper_mem[wr_addr_i] <= lower_rd;
      lower_mem[wr_addr_i] <= cell_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.rd_en) begin
      upper_raw_q <= upper_mem[rd_addr_i];
      lower_raw_q <= lower_mem[rd_addr_i];
    end
  end

  // same column written and read in one cycle (single column rows)
  always_ff @(posedge clk_i) begin
    if (ctrl_i.rd_en) begin
      byp_q       <= ctrl_i.wr_en && (wr_addr_i == rd_addr_i);
      upper_byp_q <= lower_rd;
      lower_byp_q <= cell_i;
    end
  end

  assign upper_rd = byp_q ? upper_byp_q : upper_raw_q;
  assign lower_rd = byp_q ? lower_byp_q : lower_raw_q;

  assign incoming[0] = upper_rd;
  assign incoming[1] = lower_rd;
  assign incoming[2] = cell_i;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.shift) begin
      left_q   <= centre_q;
      centre_q <= incoming;
    end
  end

  assign window_o[0] = left_q;
  assign window_o[1] = centre_q;
  assign window_o[2] = incoming;

endmodule

`default_nettype wire

// ----- rtl/gas_cell_rule.sv -----
// birth and death rule over one 3x3 neighbourhood
// depends on gas_pkg
`default_nettype none

module gas_cell_rule (
  input  gas_pkg::gas_window_t   window_i,
  input  gas_pkg::gas_mask_t     in_grid_i,
  input  gas_pkg::gas_rule_cfg_t cfg_i,
  output gas_pkg::gas_cell_t     cell_o
);
  import gas_pkg::*;

  gas_window_t cells;
  logic [3:0]  alive_cnt;
  gas_cell_t   centre;

  // positions off the grid read as alive
  always_comb begin
    for (int c = 0; c < 3; c++) begin
      for (int r = 0; r < 3; r++) begin
        cells[c][r] = in_grid_i[c][r] ? window_i[c][r] : cfg_i.alive_value;
      end
    end
  end

  always_comb begin
    alive_cnt = '0;
    for (int c = 0; c < 3; c++) begin
      for (int r = 0; r < 3; r++) begin
        if (!(c == 1 && r == 1) && cells[c][r] == cfg_i.alive_value) begin
          alive_cnt = alive_cnt + 4'd1;
        end
      end
    end
  end

  assign centre = cells[1][1];

  always_comb begin
    priority if (centre == cfg_i.alive_value) begin
      cell_o = (alive_cnt < cfg_i.death_limit) ? cfg_i.dead_value : centre;
    end else if (centre == cfg_i.dead_value) begin
      cell_o = (alive_cnt > cfg_i.birth_limit) ? cfg_i.alive_value : centre;
    end else begin
      cell_o = centre;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/grid_automaton_step.sv -----
// Grid automaton step: one generation of a 3x3 cave automaton over a raster
// cell stream. Input channel: in_valid_i / in_stall_o with mode_i and
// cell_in_i; output channel: out_valid_o / out_stall_i with cell_out_o and
// frame_last_o. A transaction completes on a clock edge with valid high and
// stall low. Every input transaction, cell or drain, takes the next raster
// position; results lag by one row plus one cell, so a frame of W x H cells
// is followed by W+1 drain transactions. The result with frame_last_o set
// closes the frame and restarts all positions.
// Throughput: one input transaction per clock while out_stall_i holds no
// result. The item register takes each input and the output register takes
// its result when the item moves on; a held result keeps the item waiting.
// The rate is set by the line buffers, one read and one write port each, one
// column per cycle while nothing stalls. Reset clears positions and valid
// flags and loads the default register values; the line buffers are not
// cleared. While out_stall_i holds a result, an item that produces a result
// waits in the item register and in_stall_o rises; lead-in items (row 0 and
// cell 0 of row 1) produce none and flow on. The user must write the
// configuration only between frames, with nothing in flight; not enforced.
`default_nettype none
`include "grid_automaton_step_assert.svh"

module grid_automaton_step #(
  parameter int unsigned MaxWidth  = gas_pkg::DefMaxWidth,
  parameter int unsigned MaxHeight = gas_pkg::DefMaxHeight
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [gas_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [gas_pkg::CfgDataW-1:0]  cfg_wdata_i,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic                          mode_i,
  input  logic [gas_pkg::CellW-1:0]     cell_in_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [gas_pkg::CellW-1:0]     cell_out_o,
  output logic                          frame_last_o
);
  import gas_pkg::*;

  localparam int unsigned ColW    = $clog2(MaxWidth);
  localparam int unsigned WidW    = $clog2(MaxWidth + 1);
  localparam int unsigned OutRowW = $clog2(MaxHeight);
  localparam int unsigned HgtW    = $clog2(MaxHeight + 1);
  localparam int unsigned InRowW  = $clog2(MaxHeight + 2);

  // configuration
  logic [GridWidthW-1:0]  grid_width_q;
  logic [GridHeightW-1:0] grid_height_q;
  gas_cell_t              alive_value_q;
  gas_cell_t              dead_value_q;
  logic [LimitW-1:0]      birth_limit_q;
  logic [LimitW-1:0]      death_limit_q;
  logic [WidW-1:0]        w_eff;
  logic [HgtW-1:0]        h_eff;

  // positions
  logic [ColW-1:0]    in_column_q, in_column_d;
  logic [InRowW-1:0]  in_row_q, in_row_d;
  logic [ColW-1:0]    out_column_q, out_column_d;
  logic [OutRowW-1:0] out_row_q, out_row_d;

  // item register
  logic      b_valid_q;
  logic      b_mode_q;
  gas_cell_t b_cell_q;
  gas_cell_t b_cell_val;

  // output register
  logic      out_valid_q;
  gas_cell_t cell_out_q;
  logic      frame_last_q;

  logic            in_acc;
  logic            b_fire;
  logic            out_ready;
  logic            emit;
  logic            last;
  logic            in_wrap;
  logic            out_wrap;
  logic            in_grid;
  logic [HgtW-1:0] h_m1;
  logic [WidW-1:0] w_m1;
  logic [HgtW-1:0] out_row_ext;
  logic [WidW-1:0] out_col_ext;
  logic [2:0]      row_ok;
  logic [2:0]      col_ok;

  gas_buf_ctrl_t buf_ctrl;
  gas_window_t   window;
  gas_mask_t     nb_mask;
  gas_rule_cfg_t rule_cfg;
  gas_cell_t     next_cell;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      grid_width_q  <= RstGridWidth;
      grid_height_q <= RstGridHeight;
      alive_value_q <= RstAliveValue;
      dead_value_q  <= RstDeadValue;
      birth_limit_q <= RstBirthLimit;
      death_limit_q <= RstDeathLimit;
    end else if (cfg_we_i) begin
      unique case (gas_reg_e'(cfg_idx_i))
        REG_GRID_WIDTH:  grid_width_q  <= cfg_wdata_i[GridWidthW-1:0];
        REG_GRID_HEIGHT: grid_height_q <= cfg_wdata_i[GridHeightW-1:0];
        REG_ALIVE_VALUE: alive_value_q <= cfg_wdata_i[CellW-1:0];
        REG_DEAD_VALUE:  dead_value_q  <= cfg_wdata_i[CellW-1:0];
        REG_BIRTH_LIMIT: birth_limit_q <= cfg_wdata_i[LimitW-1:0];
        REG_DEATH_LIMIT: death_limit_q <= cfg_wdata_i[LimitW-1:0];
        default: ;
      endcase
    end
  end

  // zero reads as one, oversize saturates
  always_comb begin
    priority if (grid_width_q == '0) begin
      w_eff = WidW'(1);
    end else if (32'(grid_width_q) > MaxWidth) begin
      w_eff = WidW'(MaxWidth);
    end else begin
      w_eff = WidW'(grid_width_q);
    end
  end

  always_comb begin
    priority if (grid_height_q == '0) begin
      h_eff = HgtW'(1);
    end else if (32'(grid_height_q) > MaxHeight) begin
      h_eff = HgtW'(MaxHeight);
    end else begin
      h_eff = HgtW'(grid_height_q);
    end
  end

  assign h_m1        = h_eff - HgtW'(1);
  assign w_m1        = w_eff - WidW'(1);
  assign out_row_ext = HgtW'(out_row_q);
  assign out_col_ext = WidW'(out_column_q);

  assign in_wrap  = ({1'b0, in_column_q} + (ColW + 1)'(1)) >= (ColW + 1)'(w_eff);
  assign out_wrap = ({1'b0, out_column_q} + (ColW + 1)'(1)) >= (ColW + 1)'(w_eff);
  assign emit     = (in_row_q >= InRowW'(2))
                 || (in_row_q == InRowW'(1) && in_column_q != '0);
  assign last     = (out_row_ext > h_m1)
                 || (out_row_ext == h_m1 && out_col_ext >= w_m1);
  assign in_grid  = (in_row_q < InRowW'(h_eff))
                 && ({1'b0, in_column_q} < (ColW + 1)'(w_eff));

  // handshake
  assign out_ready  = !out_valid_q || !out_stall_i;
  assign b_fire     = b_valid_q && (!emit || out_ready);
  assign in_stall_o = b_valid_q && !b_fire;
  assign in_acc     = in_valid_i && !in_stall_o;

  always_comb begin
    in_column_d  = in_column_q;
    in_row_d     = in_row_q;
    out_column_d = out_column_q;
    out_row_d    = out_row_q;
    if (b_fire) begin
      if (in_wrap) begin
        in_column_d = '0;
        if (in_row_q != '1) begin
          in_row_d = in_row_q + InRowW'(1);
        end
      end else begin
        in_column_d = in_column_q + ColW'(1);
      end
      if (emit) begin
        priority if (last) begin
          in_column_d  = '0;
          in_row_d     = '0;
          out_column_d = '0;
          out_row_d    = '0;
        end else if (out_wrap) begin
          out_column_d = '0;
          out_row_d    = out_row_q + OutRowW'(1);
        end else begin
          out_column_d = out_column_q + ColW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_column_q  <= '0;
      in_row_q     <= '0;
      out_column_q <= '0;
      out_row_q    <= '0;
      b_valid_q    <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      in_column_q  <= in_column_d;
      in_row_q     <= in_row_d;
      out_column_q <= out_column_d;
      out_row_q    <= out_row_d;
      if (in_acc) begin
        b_valid_q <= 1'b1;
      end else if (b_fire) begin
        b_valid_q <= 1'b0;
      end
      if (b_fire && emit) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      b_mode_q <= mode_i;
      b_cell_q <= cell_in_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (b_fire && emit) begin
      cell_out_q   <= next_cell;
      frame_last_q <= last;
    end
  end

  // drain ticks store a zero byte
  assign b_cell_val = b_mode_q ? '0 : b_cell_q;

  assign buf_ctrl.rd_en = in_acc;
  assign buf_ctrl.wr_en = b_fire && in_grid;
  assign buf_ctrl.shift = b_fire;

  gas_window #(
    .MaxWidth (MaxWidth)
  ) u_window (
    .clk_i     (clk_i),
    .ctrl_i    (buf_ctrl),
    .rd_addr_i (in_column_d),
    .wr_addr_i (in_column_q),
    .cell_i    (b_cell_val),
    .window_o  (window)
  );

  // neighbourhood positions inside the grid
  assign row_ok[0] = (out_row_q != '0) && ((out_row_ext - HgtW'(1)) < h_eff);
  assign row_ok[1] = out_row_ext < h_eff;
  assign row_ok[2] = (out_row_ext + HgtW'(1)) < h_eff;
  assign col_ok[0] = (out_column_q != '0) && ((out_col_ext - WidW'(1)) < w_eff);
  assign col_ok[1] = out_col_ext < w_eff;
  assign col_ok[2] = (out_col_ext + WidW'(1)) < w_eff;

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      for (int r = 0; r < 3; r++) begin
        nb_mask[c][r] = col_ok[c] && row_ok[r];
      end
    end
  end

  assign rule_cfg.alive_value = alive_value_q;
  assign rule_cfg.dead_value  = dead_value_q;
  assign rule_cfg.birth_limit = birth_limit_q;
  assign rule_cfg.death_limit = death_limit_q;

  gas_cell_rule u_rule (
    .window_i  (window),
    .in_grid_i (nb_mask),
    .cfg_i     (rule_cfg),
    .cell_o    (next_cell)
  );

  assign out_valid_o  = out_valid_q;
  assign cell_out_o   = cell_out_q;
  assign frame_last_o = frame_last_q;

  `GAS_ASSERT(a_load_slot_free, (b_fire && emit) |-> (!out_valid_q || !out_stall_i), "result loaded over a held result")
  `GAS_ASSERT(a_frame_restart, (b_fire && emit && last) |=> (in_column_q == '0 && in_row_q == '0 && out_column_q == '0 && out_row_q == '0), "positions not cleared after frame end")
  `GAS_ASSERT(a_result_source, $rose(out_valid_o) |-> $past(b_fire && emit), "result appeared without an emitting item")
  `GAS_ASSERT_ALWAYS(a_reset_quiet, !rst_ni |=> (!out_valid_o && !b_valid_q), "valid flags set during reset")

endmodule

`default_nettype wire
